[rtl/core/light_level_dark_detector_assert.svh]
// assertion macros shared by the checker
`ifndef LIGHT_LEVEL_DARK_DETECTOR_ASSERT_SVH
`define LIGHT_LEVEL_DARK_DETECTOR_ASSERT_SVH

// same-cycle implication, off during reset
`define LLDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LLDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lldd_pkg.sv]
package lldd_pkg;

    // block length, a power of two so the mean is a plain shift
    localparam int SAMPLES_PER_AVERAGE = 16;

    localparam int SAMPLE_W    = 10;
    localparam int TIME_W      = 32;
    localparam int MODE_W      = 2;
    localparam int OFFSET_W    = 4;
    localparam int DEBOUNCE_W  = 16;
    localparam int DWELL_W     = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    localparam int AVG_SHIFT = $clog2(SAMPLES_PER_AVERAGE);
    localparam int SUM_W     = SAMPLE_W + AVG_SHIFT;
    localparam int CNT_W     = (SAMPLES_PER_AVERAGE > 1) ? AVG_SHIFT : 1;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    localparam int DARK_BASE      = 640;
    localparam int LIGHT_BASE     = 580;
    localparam int SHIFT_PER_UNIT = 20;
    localparam int OFFSET_LIMIT   = 5;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(5000);
    localparam logic [DWELL_W-1:0]    DWELL_RESET    = DWELL_W'(60000);

    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_OFFSET = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_DWELL      = CFG_INDEX_W'(2);

    localparam logic [MODE_W-1:0] MODE_WAITING = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_RUNNING = MODE_W'(1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now_ms;
        logic [MODE_W-1:0]   macro_state;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                raw_dark;
        logic                debounced_dark;
        logic                start_show;
        logic                stop_show;
    } out_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] cal_offset;
        logic [DEBOUNCE_W-1:0]      debounce_ms;
        logic [DWELL_W-1:0]         dwell_ms;
    } cfg_t;

    // finished block handed from the accumulator to the decision stage
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] average;
        logic [TIME_W-1:0]   now_ms;
        logic [MODE_W-1:0]   mode;
    } blk_t;

    function automatic int clamp_offset(input logic signed [OFFSET_W-1:0] off);
        int o;
        o = int'(off);
        if (o > OFFSET_LIMIT) o = OFFSET_LIMIT;
        if (o < -OFFSET_LIMIT) o = -OFFSET_LIMIT;
        return o;
    endfunction

    function automatic logic [SAMPLE_W-1:0] dark_threshold(
        input logic signed [OFFSET_W-1:0] off);
        int t;
        t = DARK_BASE + clamp_offset(off) * SHIFT_PER_UNIT;
        return SAMPLE_W'(t);
    endfunction

    function automatic logic [SAMPLE_W-1:0] light_threshold(
        input logic signed [OFFSET_W-1:0] off);
        int t;
        t = LIGHT_BASE + clamp_offset(off) * SHIFT_PER_UNIT;
        return SAMPLE_W'(t);
    endfunction

endpackage

[rtl/core/lldd_accum.sv]
module lldd_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lldd_pkg::in_t       in_data,
    input  logic                blk_take,
    output lldd_pkg::blk_t      blk
);

    logic [lldd_pkg::SUM_W-1:0]    sum_reg, sum_next, sum_add;
    logic [lldd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          blk_valid_reg, blk_valid_next;
    logic [lldd_pkg::SAMPLE_W-1:0] avg_reg;
    logic [lldd_pkg::TIME_W-1:0]   now_reg;
    logic [lldd_pkg::MODE_W-1:0]   mode_reg;
    logic                          accept;
    logic                          last;

    assign in_ready = !blk_valid_reg || blk_take;
    assign accept   = in_valid && in_ready;
    assign sum_add  = sum_reg + lldd_pkg::SUM_W'(in_data.sample);
    assign last     = (cnt_reg == lldd_pkg::LAST_COUNT);

    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        blk_valid_next = blk_valid_reg;
        if (blk_take)
        begin
            blk_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (last)
            begin
                sum_next       = '0;
                cnt_next       = '0;
                blk_valid_next = 1'b1;
            end
            else
            begin
                sum_next = sum_add;
                cnt_next = cnt_reg + lldd_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            blk_valid_reg <= blk_valid_next;
        end
    end

    // mean is the top bits of the block sum
    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            avg_reg  <= sum_add[lldd_pkg::AVG_SHIFT +: lldd_pkg::SAMPLE_W];
            now_reg  <= in_data.now_ms;
            mode_reg <= in_data.macro_state;
        end
    end

    assign blk.valid   = blk_valid_reg;
    assign blk.average = avg_reg;
    assign blk.now_ms  = now_reg;
    assign blk.mode    = mode_reg;

endmodule

[rtl/core/lldd_decide.sv]
module lldd_decide (
    input  logic           clk,
    input  logic           rst_n,
    input  lldd_pkg::blk_t blk,
    input  lldd_pkg::cfg_t cfg,
    output logic           blk_take,
    output logic           out_valid,
    input  logic           out_ready,
    output lldd_pkg::out_t out_data
);

    logic                          prev_raw_reg, prev_raw_next;
    logic                          committed_reg, committed_next;
    logic [lldd_pkg::TIME_W-1:0]   raw_time_reg, raw_time_next;
    logic [lldd_pkg::TIME_W-1:0]   commit_time_reg, commit_time_next;
    logic                          out_valid_reg, out_valid_next;
    lldd_pkg::out_t                out_reg;
    lldd_pkg::out_t                out_next;

    logic [lldd_pkg::SAMPLE_W-1:0] dark_t, light_t;
    logic [lldd_pkg::TIME_W-1:0]   since_raw, since_commit;
    logic                          raw, stable, dwelt, allowed, start, stop;

    assign blk_take = blk.valid && (!out_valid_reg || out_ready);

    assign dark_t  = lldd_pkg::dark_threshold(cfg.cal_offset);
    assign light_t = lldd_pkg::light_threshold(cfg.cal_offset);

    always_comb
    begin
        // schmitt trigger, direction from the committed state
        if (!committed_reg)
            raw = (blk.average > dark_t);
        else
            raw = !(blk.average < light_t);

        raw_time_next = (raw != prev_raw_reg) ? blk.now_ms : raw_time_reg;
        since_raw     = blk.now_ms - raw_time_next;
        since_commit  = blk.now_ms - commit_time_reg;
        stable        = since_raw >= lldd_pkg::TIME_W'(cfg.debounce_ms);
        dwelt         = since_commit > lldd_pkg::TIME_W'(cfg.dwell_ms);
        allowed       = stable && dwelt;

        start = allowed && raw && (blk.mode == lldd_pkg::MODE_WAITING);
        stop  = allowed && !raw && (blk.mode == lldd_pkg::MODE_RUNNING);

        prev_raw_next    = raw;
        committed_next   = allowed ? raw : committed_reg;
        commit_time_next = (start || stop) ? blk.now_ms : commit_time_reg;

        out_next.average        = blk.average;
        out_next.raw_dark       = raw;
        out_next.debounced_dark = committed_next;
        out_next.start_show     = start;
        out_next.stop_show      = stop;

        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (blk_take)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= 1'b1;
            committed_reg   <= 1'b1;
            raw_time_reg    <= '0;
            commit_time_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (blk_take)
            begin
                prev_raw_reg    <= prev_raw_next;
                committed_reg   <= committed_next;
                raw_time_reg    <= raw_time_next;
                commit_time_reg <= commit_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_take)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/core/light_level_dark_detector.sv]
// path: the request that closes a block loads the block register, then the output register
// throughput: one sample request per cycle while in_ready is high, one result per block of samples
// the decision stage holds a single output register; a stalled output backs up
// through the block register to in_ready
// reset: async active low, clears the running sum, sets both dark states,
// zeroes change times and loads the default configuration
module light_level_dark_detector (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // sample requests
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  lldd_pkg::in_t                          in_data,
    // result requests
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output lldd_pkg::out_t                         out_data,
    // configuration writes
    input  logic                                   cfg_wen,
    input  logic [lldd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lldd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    // configuration registers
    logic signed [lldd_pkg::OFFSET_W-1:0] cal_offset_reg;
    logic [lldd_pkg::DEBOUNCE_W-1:0]      debounce_reg;
    logic [lldd_pkg::DWELL_W-1:0]         dwell_reg;
    lldd_pkg::cfg_t                       cfg;

    // block handoff between the accumulator and the decision stage
    lldd_pkg::blk_t                       blk;
    logic                                 blk_take;

    // register writes; an unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_offset_reg <= '0;
            debounce_reg   <= lldd_pkg::DEBOUNCE_RESET;
            dwell_reg      <= lldd_pkg::DWELL_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                lldd_pkg::CFG_CAL_OFFSET:
                    cal_offset_reg <= cfg_wdata[lldd_pkg::OFFSET_W-1:0];
                lldd_pkg::CFG_DEBOUNCE:
                    debounce_reg <= cfg_wdata[lldd_pkg::DEBOUNCE_W-1:0];
                lldd_pkg::CFG_DWELL:
                    dwell_reg <= cfg_wdata[lldd_pkg::DWELL_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg.cal_offset  = cal_offset_reg;
    assign cfg.debounce_ms = debounce_reg;
    assign cfg.dwell_ms    = dwell_reg;

    // running sum over the block, mean registered on the last sample
    lldd_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .blk_take (blk_take),
        .blk      (blk)
    );

    // hysteresis, debounce and dwell checks, mode requests, output register
    lldd_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk       (blk),
        .cfg       (cfg),
        .blk_take  (blk_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/core/lldd_checker.sv]
`include "light_level_dark_detector_assert.svh"

module lldd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input lldd_pkg::out_t out_data
);

    logic stalled;
    logic start_req;
    logic stop_req;
    logic dark_both;
    logic light_both;

    assign stalled    = out_valid && !out_ready;
    assign start_req  = out_valid && out_data.start_show;
    assign stop_req   = out_valid && out_data.stop_show;
    assign dark_both  = out_data.raw_dark && out_data.debounced_dark;
    assign light_both = !out_data.raw_dark && !out_data.debounced_dark;

    // a stalled result holds
    `LLDD_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_data), "stalled result changed")

    // never both requests at once
    `LLDD_ASSERT_NOW(a_req_excl, start_req, !stop_req, "start and stop together")

    // a start request commits to dark
    `LLDD_ASSERT_NOW(a_start_dark, start_req, dark_both, "start without dark commit")

    // a stop request commits to light
    `LLDD_ASSERT_NOW(a_stop_light, stop_req, light_both, "stop without light commit")

endmodule

bind light_level_dark_detector lldd_checker u_lldd_checker (.*);

[sim/tb_top.sv]
module tb_top;

    import lldd_pkg::*;

    // index with no register behind it, writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = CFG_INDEX_W'(3);

    // cycles to let the decision stage drain before a register write
    localparam int DRAIN_CYCLES = 6;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_t                    in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_t                   out_data;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    light_level_dark_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the detector: running block sum, trigger and commit state
    int unsigned                acc_sum;
    int unsigned                acc_count;
    logic                       last_raw_dark;
    logic                       held_dark;
    logic [TIME_W-1:0]          raw_flip_ms;
    logic [TIME_W-1:0]          commit_ms;

    // shadow copy of the registers
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [DEBOUNCE_W-1:0]      debounce_reg;
    logic [DWELL_W-1:0]         dwell_reg;

    // block reports still owed by the detector, oldest first
    out_t                       block_reports[$];
    int                         mismatch_count;

    // stimulus side: system mode follows the start and stop requests
    logic [MODE_W-1:0]          sys_mode;
    logic [TIME_W-1:0]          clock_ms;
    int                         idle_pct;
    int                         stall_pct;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the detector hangs
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // -------------------------------------------------------------------------
    // thresholds under the current offset, clamped to the legal range
    // -------------------------------------------------------------------------
    function automatic int threshold_shift();
        int o;
        o = int'(offset_reg);
        if (o > OFFSET_LIMIT)
            o = OFFSET_LIMIT;
        if (o < -OFFSET_LIMIT)
            o = -OFFSET_LIMIT;
        return o * SHIFT_PER_UNIT;
    endfunction

    function automatic int dark_limit();
        return DARK_BASE + threshold_shift();
    endfunction

    function automatic int light_limit();
        return LIGHT_BASE + threshold_shift();
    endfunction

    // -------------------------------------------------------------------------
    // fold one accepted sample into the shadow state; a block end owes a report
    // -------------------------------------------------------------------------
    task automatic track_sample(input in_t item);
        logic [SAMPLE_W-1:0] mean;
        logic                raw;
        logic                steady;
        logic                aged;
        logic [TIME_W-1:0]   since_flip;
        logic [TIME_W-1:0]   since_commit;
        out_t                report;

        acc_sum += item.sample;
        acc_count++;
        // mid block: only the sum and the count move
        if (acc_count < SAMPLES_PER_AVERAGE)
            return;

        mean = SAMPLE_W'(acc_sum / SAMPLES_PER_AVERAGE);
        acc_sum = 0;
        acc_count = 0;

        // schmitt trigger, direction picked by the committed state
        if (!held_dark)
            raw = (int'(mean) > dark_limit());
        else
            raw = !(int'(mean) < light_limit());

        if (raw != last_raw_dark)
        begin
            raw_flip_ms = item.now_ms;
            last_raw_dark = raw;
        end

        // ages wrap modulo 2^32
        since_flip = item.now_ms - raw_flip_ms;
        since_commit = item.now_ms - commit_ms;
        steady = (since_flip >= TIME_W'(debounce_reg));
        aged = (since_commit > TIME_W'(dwell_reg));

        report = '0;
        report.average = mean;
        report.raw_dark = raw;
        if (steady && aged)
        begin
            held_dark = raw;
            // modes other than waiting and running raise nothing
            if (raw && item.macro_state == MODE_WAITING)
            begin
                commit_ms = item.now_ms;
                report.start_show = 1'b1;
                sys_mode = MODE_RUNNING;
            end
            else if (!raw && item.macro_state == MODE_RUNNING)
            begin
                commit_ms = item.now_ms;
                report.stop_show = 1'b1;
                sys_mode = MODE_WAITING;
            end
        end
        report.debounced_dark = held_dark;
        block_reports.push_back(report);
    endtask

    // -------------------------------------------------------------------------
    // check every accepted result against the oldest owed report
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (block_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: avg=%0d raw=%0b deb=%0b start=%0b stop=%0b",
                             out_data.average, out_data.raw_dark, out_data.debounced_dark,
                             out_data.start_show, out_data.stop_show);
            end
            else
            begin
                due = block_reports.pop_front();
                if (out_data.average !== due.average
                    || out_data.raw_dark !== due.raw_dark
                    || out_data.debounced_dark !== due.debounced_dark
                    || out_data.start_show !== due.start_show
                    || out_data.stop_show !== due.stop_show)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected avg=%0d raw=%0b deb=%0b start=%0b stop=%0b",
                                 due.average, due.raw_dark, due.debounced_dark,
                                 due.start_show, due.stop_show);
                        $display("          got      avg=%0d raw=%0b deb=%0b start=%0b stop=%0b",
                                 out_data.average, out_data.raw_dark, out_data.debounced_dark,
                                 out_data.start_show, out_data.stop_show);
                    end
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // handshake helpers
    // -------------------------------------------------------------------------

    // one sample request; valid stays up across back-to-back requests
    task automatic send_sample(input in_t item);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        track_sample(item);
    endtask

    // drop valid, wait for owed reports, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        while (block_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write; upper data bits are random and must be ignored
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] word);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        @(posedge clk);
        case (idx)
            CFG_CAL_OFFSET: offset_reg = word[OFFSET_W-1:0];
            CFG_DEBOUNCE:   debounce_reg = word[DEBOUNCE_W-1:0];
            CFG_DWELL:      dwell_reg = word[DWELL_W-1:0];
            default:        ;
        endcase
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_offset(input int off);
        write_reg(CFG_CAL_OFFSET, {20'($urandom), 4'(off)});
    endtask

    task automatic set_timing(input int unsigned debounce, input int unsigned dwell);
        write_reg(CFG_DEBOUNCE, {8'($urandom), 16'(debounce)});
        write_reg(CFG_DWELL, 24'(dwell));
    endtask

    task automatic set_idling(input idle_mode_e mode);
        idle_pct = (mode == IDLE_SENDER) ? 55 : (mode == IDLE_BOTH) ? 35 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 55 : (mode == IDLE_BOTH) ? 35 : 0;
    endtask

    // -------------------------------------------------------------------------
    // block-shaped stimulus: each block sits near one light level with noise,
    // mode mostly follows the requests, time mostly moves forward
    // -------------------------------------------------------------------------
    task automatic run_blocks(input int n_items, input int unsigned step_max);
        int   level;
        int   noise;
        int   s;
        int   pick;
        in_t  item;

        level = 0;
        noise = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (acc_count == 0)
            begin
                case ($urandom_range(5))
                    0: level = dark_limit() + $urandom_range(0, 40) - 20;
                    1: level = light_limit() + $urandom_range(0, 40) - 20;
                    2: level = $urandom_range(800, 1023);
                    3: level = $urandom_range(0, 400);
                    4: level = $urandom_range(0, 1023);
                    default: level = $urandom_range(1) ? 1023 : 0;
                endcase
                noise = $urandom_range(0, 64);
            end

            // occasional stray reading
            if ($urandom_range(19) == 0)
                s = $urandom_range(0, 1023);
            else
                s = level + $urandom_range(0, 2 * noise) - noise;
            if (s < 0)
                s = 0;
            if (s > 1023)
                s = 1023;

            // time: steady steps, rare jumps and rewinds
            pick = $urandom_range(999);
            if (pick == 0)
                clock_ms += $urandom;
            else if (pick == 1)
                clock_ms = $urandom;
            else
                clock_ms += $urandom_range(0, step_max);

            // block end sometimes lands right on the dwell or debounce edge
            if (acc_count == SAMPLES_PER_AVERAGE - 1)
            begin
                case ($urandom_range(7))
                    0: clock_ms = commit_ms + TIME_W'(dwell_reg) + $urandom_range(0, 1);
                    1: clock_ms = raw_flip_ms + TIME_W'(debounce_reg) - $urandom_range(0, 1);
                    default: ;
                endcase
            end

            item.sample = SAMPLE_W'(s);
            item.now_ms = clock_ms;
            item.macro_state = ($urandom_range(9) == 0) ? MODE_W'($urandom_range(3)) : sys_mode;
            send_sample(item);
        end
    endtask

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // field extremes under reset settings: a full-dark block closing in mode
    // three at the top of the time range, then a bright partial block
    task automatic test_field_extremes();
        in_t item;
        set_idling(IDLE_NONE);
        for (int i = 0; i < 24; i++)
        begin
            item.sample = (i < SAMPLES_PER_AVERAGE) ? SAMPLE_W'(1023) : SAMPLE_W'(0);
            if (i == 0)
                item.now_ms = '0;
            else if (i == SAMPLES_PER_AVERAGE - 1)
                item.now_ms = '1;
            else
                item.now_ms = TIME_W'(i * 1000);
            item.macro_state = MODE_W'(i % 4);
            send_sample(item);
        end
        clock_ms = 32'd100;
        settle();
    endtask

    // offset sweep including values past the clamp on both sides
    task automatic test_offset_sweep();
        int offsets[6];
        offsets = '{-8, -5, 0, 5, 7, -2};
        set_idling(IDLE_SENDER);
        set_timing($urandom_range(0, 2000), $urandom_range(0, 5000));
        foreach (offsets[k])
        begin
            settle();
            set_offset(offsets[k]);
            run_blocks(54, 300);
        end
        settle();
    endtask

    // zero debounce and dwell, then both at their maximum with long steps
    task automatic test_timing_extremes();
        set_idling(IDLE_RECEIVER);
        set_offset(0);
        set_timing(0, 0);
        run_blocks(96, 50);
        settle();
        set_timing(16'hFFFF, 24'hFF_FFFF);
        run_blocks(96, 400000);
        settle();
    endtask

    // reset timing values while the clock wraps through zero
    task automatic test_time_wrap();
        set_idling(IDLE_BOTH);
        set_timing(5000, 60000);
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40000);
        run_blocks(128, 600);
        settle();
    endtask

    // random settings per phase, idling styles in rotation
    task automatic test_random_mix();
        for (int ph = 0; ph < 8; ph++)
        begin
            set_idling(idle_mode_e'(ph % 4));
            if (ph == 0)
                write_reg(CFG_UNUSED, 24'($urandom));
            write_reg(CFG_CAL_OFFSET, 24'($urandom));
            set_timing($urandom_range(0, 20000), $urandom_range(0, 100000));
            run_blocks(64, $urandom_range(50, 2000));
            settle();
        end
    endtask

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_wen <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;

        // shadow state matches the detector after reset
        acc_sum = 0;
        acc_count = 0;
        last_raw_dark = 1'b1;
        held_dark = 1'b1;
        raw_flip_ms = '0;
        commit_ms = '0;
        offset_reg = '0;
        debounce_reg = DEBOUNCE_RESET;
        dwell_reg = DWELL_RESET;
        mismatch_count = 0;
        sys_mode = MODE_WAITING;
        clock_ms = '0;
        idle_pct = 0;
        stall_pct = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_offset_sweep();
        test_timing_extremes();
        test_time_wrap();
        test_random_mix();

        settle();
        if (mismatch_count == 0 && block_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
